FILE: src/sitda_pkg.sv
// Shared types and character constants for the signed integer to decimal text block.
`timescale 1ns / 1ps

package sitda_pkg;

   localparam int CODE_WIDTH = 6;

   // ASCII codes, cut to the six bits that the result port carries
   localparam logic [CODE_WIDTH-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [CODE_WIDTH-1:0] CHAR_MINUS = 6'd45;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } dab_status_type;

endpackage

FILE: src/signed_int_to_decimal_ascii.sv
// Top level: signed integer in, decimal ASCII text out, one character per transfer.
//
// Input channel req_: one transfer carries req_value, a two's complement integer of
// VALUE_WIDTH bits. req_stall is high while a number is being converted or emitted.
// Result channel rsp_: one transfer per character, most significant first, with a
// leading '-' for negative values; rsp_is_last marks the final character of a number.
// Zero gives the single character "0"; the most negative value converts correctly.
//
// Timing: after the input transfer, the shift-and-add-3 converter takes one magnitude
// bit per cycle, the conversion state then hands the BCD digits to the emitter, and
// characters leave at one per cycle while the receiver does not hold rsp_stall.
// The next input is taken as soon as the last character sits in the output register.
//
// Reset (synchronous, active high) drops any number in progress and clears rsp_valid.
// While the receiver holds rsp_stall against a valid character, the output register and
// the emitter wait; the character on the port does not change until it is transferred.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii import sitda_pkg::*; #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [VALUE_WIDTH-1:0] req_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [CODE_WIDTH-1:0]         rsp_char_code,
   output logic                          rsp_is_last
);

   // decimal digits of 2^(VALUE_WIDTH-1), the largest magnitude
   localparam int DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
   localparam int IDX_W  = $clog2(DIGITS);

   state_type              state_ff, state_in;
   logic                   neg_ff, neg_in;
   logic                   dash_ff, dash_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CODE_WIDTH-1:0]  rsp_char_ff, rsp_char_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   start;
   logic [VALUE_WIDTH-1:0] value_u;
   logic [VALUE_WIDTH-1:0] magnitude;
   dab_status_type         dab_status;
   logic [DIGITS*4-1:0]    bcd;
   logic [IDX_W-1:0]       top_idx;
   logic [3:0]             cur_digit;
   logic                   slot_free;

   // negating the most negative value wraps to 2^(W-1), which is right as unsigned
   assign value_u   = $unsigned(req_value);
   assign magnitude = value_u[VALUE_WIDTH-1] ? (~value_u + 1'b1) : value_u;

   sitda_dabble #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIGITS      (DIGITS)
   ) u_dabble (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .magnitude (magnitude),
      .status    (dab_status),
      .bcd       (bcd)
   );

   // highest nonzero digit; stays 0 for a zero magnitude
   always_comb begin
      top_idx = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd[i*4 +: 4] != 4'd0) begin
            top_idx = IDX_W'(i);
         end
      end
   end

   assign cur_digit = bcd[idx_ff*4 +: 4];
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      dash_in      = dash_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      start        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               start    = 1'b1;
               neg_in   = value_u[VALUE_WIDTH-1];
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (dab_status.done) begin
               idx_in   = top_idx;
               dash_in  = neg_ff;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (dash_ff) begin
                  // at least one digit always follows the sign
                  rsp_char_in = CHAR_MINUS;
                  rsp_last_in = 1'b0;
                  dash_in     = 1'b0;
               end else begin
                  rsp_char_in = CHAR_ZERO + {2'b00, cur_digit};
                  rsp_last_in = (idx_ff == '0);
                  if (idx_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     idx_in = idx_ff - 1'b1;
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      dash_ff     <= dash_in;
      idx_ff      <= idx_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = rsp_char_ff;
   assign rsp_is_last   = rsp_last_ff;

   // converter only reports completion while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset)
      dab_status.done |-> (state_ff == ST_CONV))
      else $error("converter done outside conversion state");

   // while converting, the converter is running or just finished
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> (dab_status.busy || dab_status.done))
      else $error("conversion state with idle converter");

   // a sign character is never the end of a number
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_char_code == CHAR_MINUS)) |-> !rsp_is_last)
      else $error("minus sign flagged as last character");

   // an accepted number, taken only after the previous one has emitted its last character, starts the converter
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_CONV && dab_status.busy))
      else $error("accepted input did not start conversion");

endmodule

FILE: src/sitda_dabble.sv
// Iterative shift-and-add-3 binary to BCD converter, one magnitude bit per cycle.
`timescale 1ns / 1ps

module sitda_dabble import sitda_pkg::*; #(
   parameter int VALUE_WIDTH = 32,
   parameter int DIGITS      = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [VALUE_WIDTH-1:0]   magnitude,
   output dab_status_type           status,
   output logic [DIGITS*4-1:0]      bcd
);

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] bin_ff, bin_in;
   logic [DIGITS*4-1:0]    bcd_ff, bcd_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [DIGITS*4-1:0]    adj;

   // digits of 5 or more get +3 so that the shift carries into the next digit
   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = magnitude;
         bcd_in  = '0;
         cnt_in  = CNT_W'(VALUE_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         {bcd_in, bin_in} = {adj[DIGITS*4-2:0], bin_ff, 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;

endmodule

FILE: tb/signed_int_to_decimal_ascii_tb.sv
// Testbench for signed_int_to_decimal_ascii: directed and random numbers checked per character.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_tb;
   import sitda_pkg::*;

   localparam int VALUE_WIDTH = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 300;
   localparam int TAIL_CYCLES = 80;

   typedef enum logic { RX_FREE, RX_PATTERN } rx_mode_type;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [CODE_WIDTH-1:0]         code;
      logic                          last;
   } text_char_type;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_stall;
   logic signed [VALUE_WIDTH-1:0] req_value;
   logic                          rsp_valid;
   logic                          rsp_stall;
   logic [CODE_WIDTH-1:0]         rsp_char_code;
   logic                          rsp_is_last;

   text_char_type expected_text[$];
   int            error_count = 0;
   int            cycle_count = 0;
   rx_mode_type   rx_mode = RX_FREE;
   int            hold_requests = 0;
   int            burst_left = 0;

   signed_int_to_decimal_ascii #(.VALUE_WIDTH(VALUE_WIDTH)) u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_code (rsp_char_code),
      .rsp_is_last   (rsp_is_last)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
                  expected_text.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      error_count++;
   endtask

   // Expected decimal text of one number; magnitude is one bit wider so the most
   // negative value does not overflow.
   function automatic void predict_text(input logic signed [VALUE_WIDTH-1:0] v);
      logic [VALUE_WIDTH:0] mag;
      logic                 neg;
      int                   digit_buf[0:20];
      int                   nd;
      int                   total;
      int                   pos;
      text_char_type        ch;
      neg = v[VALUE_WIDTH-1];
      mag = neg ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
      nd = 0;
      do begin
         digit_buf[nd] = int'(mag % 10);
         mag = mag / 10;
         nd++;
      end while (mag != 0);
      total = nd + (neg ? 1 : 0);
      pos = 0;
      ch.value = v;
      if (neg) begin
         ch.code = CHAR_MINUS;
         ch.last = (total == 1);
         expected_text.push_back(ch);
         pos = 1;
      end
      for (int k = nd - 1; k >= 0; k--) begin
         ch.code = CHAR_ZERO + CODE_WIDTH'(digit_buf[k]);
         ch.last = (pos == total - 1);
         expected_text.push_back(ch);
         pos++;
      end
   endfunction

   function automatic logic signed [VALUE_WIDTH-1:0] random_value();
      int unsigned                   pick;
      int unsigned                   p;
      logic signed [VALUE_WIDTH-1:0] v;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1, 2: v = $urandom;
         3, 4:    v = $urandom >> $urandom_range(0, 31);
         5:       v = $urandom_range(0, 12);
         6, 7: begin
            // around a power of ten, where the digit count changes
            p = 1;
            repeat ($urandom_range(0, 9)) p = p * 10;
            v = p + $urandom_range(0, 2) - 1;
         end
         8:       v = 32'h8000_0000 + $urandom_range(0, 3);
         default: v = 32'h7FFF_FFFF - $urandom_range(0, 3);
      endcase
      if (pick >= 3 && pick <= 7 && $urandom_range(0, 1))
         v = -v;
      return v;
   endfunction

   // One input transfer; valid stays high afterwards until the caller idles or sends again.
   task automatic send_number(input logic signed [VALUE_WIDTH-1:0] v);
      @(negedge clock);
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!(req_valid === 1'b1 && req_stall === 1'b0));
      predict_text(v);
   endtask

   task automatic sender_idle(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_drained();
      sender_idle(1);
      while (expected_text.size() != 0) @(posedge clock);
   endtask

   task automatic send_burst(input int count, input bit with_gaps);
      for (int i = 0; i < count; i++) begin
         send_number(random_value());
         if (with_gaps) begin
            if (burst_left == 0) begin
               sender_idle($urandom_range(1, 60));
               burst_left = $urandom_range(1, 12);
            end else begin
               burst_left--;
            end
         end
      end
   endtask

   // Receiver stall: long hold-offs on request, otherwise a random bit pattern in pattern mode, else no stall.
   always @(negedge clock) begin : rx_stall_gen
      static int          hold_seen = 0;
      static int          hold_left = 0;
      static logic [15:0] pattern = '0;
      static int          pattern_left = 0;
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else if (rx_mode == RX_PATTERN) begin
         if (pattern_left == 0) begin
            case ($urandom_range(0, 3))
               0:       pattern = '0;
               1:       pattern = 16'($urandom & $urandom);
               2:       pattern = 16'($urandom);
               default: pattern = 16'($urandom | $urandom);
            endcase
            pattern_left = 16;
         end
         rsp_stall <= pattern[0];
         pattern = pattern >> 1;
         pattern_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : rx_check
      text_char_type want;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("character %0d arrived with none expected", rsp_char_code));
         end else begin
            want = expected_text.pop_front();
            if (rsp_char_code !== want.code)
               report_mismatch($sformatf("value %0d: char_code %0d, expected %0d",
                                         want.value, rsp_char_code, want.code));
            if (rsp_is_last !== want.last)
               report_mismatch($sformatf("value %0d char %0d: is_last %b, expected %b",
                                         want.value, want.code, rsp_is_last, want.last));
         end
      end
   end

   task automatic test_directed();
      logic signed [VALUE_WIDTH-1:0] list[$];
      list = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 123456789, -987654321,
               999999999, 1000000000, -1000000000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0001, 32'h7FFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555, 0};
      rx_mode = RX_PATTERN;
      foreach (list[i]) begin
         send_number(list[i]);
         if ($urandom_range(0, 3) == 0) sender_idle($urandom_range(1, 50));
      end
      wait_drained();
   endtask

   task automatic test_random_bursts();
      rx_mode = RX_PATTERN;
      burst_left = 0;
      send_burst(95, 1'b1);
      wait_drained();
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering numbers.
   task automatic test_backpressure();
      rx_mode = RX_FREE;
      hold_requests++;
      send_burst(10, 1'b0);
      wait_drained();
   endtask

   // Sender stops until every character is out, then resumes.
   task automatic test_drain_pause();
      rx_mode = RX_PATTERN;
      send_burst(10, 1'b1);
      wait_drained();
      send_burst(10, 1'b1);
      wait_drained();
   endtask

   task automatic test_full_rate();
      rx_mode = RX_FREE;
      send_burst(25, 1'b0);
      wait_drained();
   endtask

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_bursts();
      test_backpressure();
      test_drain_pause();
      test_full_rate();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_text.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: filelist.f
src/sitda_pkg.sv
src/sitda_dabble.sv
src/signed_int_to_decimal_ascii.sv
tb/signed_int_to_decimal_ascii_tb.sv
